FILE: rtl/i2cm_pkg.sv
// Shared types, codes and line decoding for the I2C register access master.
package i2cm_pkg;

	localparam int OP_W      = 2;
	localparam int BYTE_W    = 8;
	localparam int ADDR_W    = 7;
	localparam int TICKS_W   = 16;
	localparam int TIMEOUT_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

	localparam logic [ADDR_W-1:0]    DEV_ADDR_RST = 7'd76;
	localparam logic [TICKS_W-1:0]   TICKS_RST    = 16'd5;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 8'd255;

	// Bus sequencer phases. Start and byte groups are four phases each,
	// so the low two bits minus one give the offset inside the group.
	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_ST1_A   = 5'd1,
		PH_ST1_B   = 5'd2,
		PH_ST1_C   = 5'd3,
		PH_ST1_D   = 5'd4,
		PH_AW_BL   = 5'd5,
		PH_AW_BH   = 5'd6,
		PH_AW_KL   = 5'd7,
		PH_AW_KH   = 5'd8,
		PH_RG_BL   = 5'd9,
		PH_RG_BH   = 5'd10,
		PH_RG_KL   = 5'd11,
		PH_RG_KH   = 5'd12,
		PH_DT_BL   = 5'd13,
		PH_DT_BH   = 5'd14,
		PH_DT_KL   = 5'd15,
		PH_DT_KH   = 5'd16,
		PH_ST2_A   = 5'd17,
		PH_ST2_B   = 5'd18,
		PH_ST2_C   = 5'd19,
		PH_ST2_D   = 5'd20,
		PH_AR_BL   = 5'd21,
		PH_AR_BH   = 5'd22,
		PH_AR_KL   = 5'd23,
		PH_AR_KH   = 5'd24,
		PH_RD_LOW  = 5'd25,
		PH_RD_HIGH = 5'd26,
		PH_MN_LOW  = 5'd27,
		PH_MN_HIGH = 5'd28,
		PH_SP_LOW  = 5'd29,
		PH_SP_HIGH = 5'd30,
		PH_SP_END  = 5'd31
	} phase_t;

	function automatic logic is_start_grp(phase_t p);
		return ((p >= PH_ST1_A) && (p <= PH_ST1_D)) || ((p >= PH_ST2_A) && (p <= PH_ST2_D));
	endfunction

	function automatic logic is_byte_grp(phase_t p);
		return ((p >= PH_AW_BL) && (p <= PH_DT_KH)) || ((p >= PH_AR_BL) && (p <= PH_AR_KH));
	endfunction

	// Line levels for a phase: bit 1 SCL level, bit 0 SDA released.
	function automatic logic [1:0] lines_of(phase_t p, logic msb);
		logic [1:0] off;
		logic [1:0] lines;
		off = p[1:0] - 2'd1;
		lines = 2'b10;
		if ((p == PH_IDLE) || (p == PH_SP_END)) begin
			lines = 2'b11;
		end else if (is_start_grp(p)) begin
			case (off)
				2'd0:    lines = 2'b01;
				2'd1:    lines = 2'b11;
				2'd2:    lines = 2'b10;
				default: lines = 2'b00;
			endcase
		end else if (is_byte_grp(p)) begin
			case (off)
				2'd0:    lines = {1'b0, msb};
				2'd1:    lines = {1'b1, msb};
				2'd2:    lines = 2'b01;
				default: lines = 2'b11;
			endcase
		end else begin
			case (p)
				PH_RD_LOW, PH_MN_LOW:   lines = 2'b01;
				PH_RD_HIGH, PH_MN_HIGH: lines = 2'b11;
				PH_SP_LOW:              lines = 2'b00;
				default:                lines = 2'b10;
			endcase
		end
		return lines;
	endfunction

endpackage

FILE: rtl/i2cm_if.sv
// Command and result channel interfaces of the I2C register access master.
interface i2cm_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [i2cm_pkg::OP_W-1:0]      operation;
	logic [i2cm_pkg::BYTE_W-1:0]    register_address;
	logic [i2cm_pkg::BYTE_W-1:0]    write_data;
	logic                           sda_in;

	modport source (output valid, output operation, output register_address,
		output write_data, output sda_in, input ready);
	modport sink (input valid, input operation, input register_address,
		input write_data, input sda_in, output ready);
endinterface

interface i2cm_res_if;
	logic                           valid;
	logic                           ready;
	logic                           scl_level;
	logic                           sda_pull_low;
	logic                           busy_res;
	logic                           done_res;
	logic [i2cm_pkg::BYTE_W-1:0]    read_result;
	logic                           nack_seen;

	modport source (output valid, output scl_level, output sda_pull_low, output busy_res,
		output done_res, output read_result, output nack_seen, input ready);
	modport sink (input valid, input scl_level, input sda_pull_low, input busy_res,
		input done_res, input read_result, input nack_seen, output ready);
endinterface

FILE: rtl/i2c_register_access_master_core.sv
// Top level of the I2C register access master: input stage, bus sequencer, result register.
//
//  channel | dir | handshake     | carries
//  cmd     | in  | valid/ready   | operation, register_address, write_data, sda_in
//  res     | out | valid/ready   | scl_level, sda_pull_low, busy_res, done_res,
//          |     |               | read_result, nack_seen
//  cfg     | in  | wr_en only    | wr_index selects register, wr_data carries value
//
// Each transaction in gives one out, passing the input register and the result register.
// Throughput is one transaction per cycle unless the result is stalled: the sequencer state
// updates on each step, between the input register (_s1) and the result register.
// Reset (arst_n low) idles the sequencer, releases both lines, loads register defaults.
// A stalled result holds the input register; cmd.ready drops only while both are full.
// Timed phases last ticks_q transactions (min one); acknowledges poll once per transaction.
module i2c_register_access_master_core (
	input  logic                            clk,
	input  logic                            arst_n,
	i2cm_cmd_if.sink                        cmd,
	i2cm_res_if.source                      res,
	input  logic                            wr_en,
	input  logic [i2cm_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [i2cm_pkg::CFG_DAT_W-1:0]  wr_data
);

	// Configuration registers
	logic [i2cm_pkg::ADDR_W-1:0]    dev_addr_q;
	logic [i2cm_pkg::TICKS_W-1:0]   ticks_q;
	logic [i2cm_pkg::TIMEOUT_W-1:0] timeout_q;

	// Input stage
	logic                           valid_s1;
	logic [i2cm_pkg::OP_W-1:0]      op_s1;
	logic [i2cm_pkg::BYTE_W-1:0]    reg_s1;
	logic [i2cm_pkg::BYTE_W-1:0]    data_s1;
	logic                           sda_s1;

	// Sequencer state
	i2cm_pkg::phase_t               phase_q, phase_n;
	logic [2:0]                     bit_q, bit_n;
	logic [i2cm_pkg::BYTE_W-1:0]    shift_q, shift_n;
	logic [i2cm_pkg::TICKS_W-1:0]   wait_q, wait_n;
	logic [i2cm_pkg::TIMEOUT_W-1:0] poll_q, poll_n;
	logic                           is_read_q, is_read_n;
	logic [i2cm_pkg::BYTE_W-1:0]    held_reg_q, held_reg_n;
	logic [i2cm_pkg::BYTE_W-1:0]    held_data_q, held_data_n;
	logic [i2cm_pkg::BYTE_W-1:0]    read_q, read_n;
	logic                           nack_q, nack_n;

	// Result register
	logic                           res_valid_q;
	logic                           scl_q, pull_q, busy_q, done_q, nack_out_q;
	logic [i2cm_pkg::BYTE_W-1:0]    read_out_q;

	logic                           step;
	logic [1:0]                     lines;

	// Advance the input stage whenever the result slot is free or being drained.
	assign step      = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || step;

	// Configuration writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= i2cm_pkg::DEV_ADDR_RST;
			ticks_q    <= i2cm_pkg::TICKS_RST;
			timeout_q  <= i2cm_pkg::TIMEOUT_RST;
		end else if (wr_en) begin
			case (wr_index)
				i2cm_pkg::CFG_DEV_ADDR: dev_addr_q <= wr_data[i2cm_pkg::ADDR_W-1:0];
				i2cm_pkg::CFG_TICKS:    ticks_q    <= wr_data[i2cm_pkg::TICKS_W-1:0];
				i2cm_pkg::CFG_TIMEOUT:  timeout_q  <= wr_data[i2cm_pkg::TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: capture an accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1   <= cmd.operation;
			reg_s1  <= cmd.register_address;
			data_s1 <= cmd.write_data;
			sda_s1  <= cmd.sda_in;
		end
	end

	// Next-state logic of the bus sequencer.
	always_comb begin
		logic [i2cm_pkg::TICKS_W-1:0]   wsum;
		logic [i2cm_pkg::TIMEOUT_W-1:0] psum;
		logic                           elapsed;
		logic [1:0]                     off;
		logic [4:0]                     base;
		logic                           enter_en;
		i2cm_pkg::phase_t               enter_ph;
		logic                           load_en;
		logic [i2cm_pkg::BYTE_W-1:0]    load_val;
		logic                           ack_go;

		phase_n     = phase_q;
		bit_n       = bit_q;
		shift_n     = shift_q;
		wait_n      = wait_q;
		poll_n      = poll_q;
		is_read_n   = is_read_q;
		held_reg_n  = held_reg_q;
		held_data_n = held_data_q;
		read_n      = read_q;
		nack_n      = nack_q;

		wsum     = wait_q + 16'd1;
		psum     = poll_q + 8'd1;
		elapsed  = (wsum >= ticks_q);
		off      = phase_q[1:0] - 2'd1;
		base     = phase_q - {3'd0, off};
		enter_en = 1'b0;
		enter_ph = phase_q;
		load_en  = 1'b0;
		load_val = '0;
		ack_go   = 1'b0;

		if (phase_q == i2cm_pkg::PH_IDLE) begin
			// Latch operands on a command; any other code idles.
			if ((op_s1 == i2cm_pkg::OP_WRITE) || (op_s1 == i2cm_pkg::OP_READ)) begin
				held_reg_n  = reg_s1;
				held_data_n = data_s1;
				is_read_n   = (op_s1 == i2cm_pkg::OP_READ);
				nack_n      = 1'b0;
				enter_en    = 1'b1;
				enter_ph    = i2cm_pkg::PH_ST1_A;
			end
		end else if (i2cm_pkg::is_start_grp(phase_q)) begin
			wait_n = wsum;
			if (elapsed) begin
				enter_en = 1'b1;
				if (phase_q == i2cm_pkg::PH_ST1_D) begin
					load_en  = 1'b1;
					load_val = {dev_addr_q, 1'b0};
					enter_ph = i2cm_pkg::PH_AW_BL;
				end else if (phase_q == i2cm_pkg::PH_ST2_D) begin
					load_en  = 1'b1;
					load_val = {dev_addr_q, 1'b1};
					enter_ph = i2cm_pkg::PH_AR_BL;
				end else begin
					enter_ph = i2cm_pkg::phase_t'(phase_q + 5'd1);
				end
			end
		end else if (i2cm_pkg::is_byte_grp(phase_q)) begin
			case (off)
				2'd0: begin
					wait_n = wsum;
					if (elapsed) begin
						enter_en = 1'b1;
						enter_ph = i2cm_pkg::phase_t'(base + 5'd1);
					end
				end
				2'd1: begin
					wait_n = wsum;
					if (elapsed) begin
						shift_n  = {shift_q[6:0], 1'b0};
						bit_n    = bit_q + 3'd1;
						enter_en = 1'b1;
						enter_ph = (bit_n == 3'd0) ? i2cm_pkg::phase_t'(base + 5'd2)
							: i2cm_pkg::phase_t'(base);
					end
				end
				2'd2: begin
					wait_n = wsum;
					if (elapsed) begin
						enter_en = 1'b1;
						enter_ph = i2cm_pkg::phase_t'(base + 5'd3);
					end
				end
				default: begin
					// Poll the acknowledge; a timeout marks nack and moves on.
					poll_n = psum;
					if (!sda_s1) begin
						ack_go = 1'b1;
					end else if (psum == timeout_q) begin
						nack_n = 1'b1;
						ack_go = 1'b1;
					end
				end
			endcase
			if (ack_go) begin
				enter_en = 1'b1;
				case (i2cm_pkg::phase_t'(base))
					i2cm_pkg::PH_AW_BL: begin
						load_en  = 1'b1;
						load_val = held_reg_q;
						enter_ph = i2cm_pkg::PH_RG_BL;
					end
					i2cm_pkg::PH_RG_BL: begin
						if (is_read_q) begin
							enter_ph = i2cm_pkg::PH_ST2_A;
						end else begin
							load_en  = 1'b1;
							load_val = held_data_q;
							enter_ph = i2cm_pkg::PH_DT_BL;
						end
					end
					i2cm_pkg::PH_DT_BL: begin
						enter_ph = i2cm_pkg::PH_SP_LOW;
					end
					default: begin
						load_en  = 1'b1;
						load_val = '0;
						enter_ph = i2cm_pkg::PH_RD_LOW;
					end
				endcase
			end
		end else begin
			case (phase_q)
				i2cm_pkg::PH_RD_LOW: begin
					wait_n = wsum;
					if (elapsed) begin
						enter_en = 1'b1;
						enter_ph = i2cm_pkg::PH_RD_HIGH;
					end
				end
				i2cm_pkg::PH_RD_HIGH: begin
					wait_n = wsum;
					if (elapsed) begin
						shift_n  = {shift_q[6:0], sda_s1};
						bit_n    = bit_q + 3'd1;
						enter_en = 1'b1;
						if (bit_n == 3'd0) begin
							read_n   = shift_n;
							enter_ph = i2cm_pkg::PH_MN_LOW;
						end else begin
							enter_ph = i2cm_pkg::PH_RD_LOW;
						end
					end
				end
				i2cm_pkg::PH_MN_LOW, i2cm_pkg::PH_MN_HIGH,
				i2cm_pkg::PH_SP_LOW, i2cm_pkg::PH_SP_HIGH: begin
					wait_n = wsum;
					if (elapsed) begin
						enter_en = 1'b1;
						enter_ph = i2cm_pkg::phase_t'(phase_q + 5'd1);
					end
				end
				default: begin
					// Stop completes: release SDA and return to idle.
					enter_en = 1'b1;
					enter_ph = i2cm_pkg::PH_IDLE;
				end
			endcase
		end

		if (enter_en) begin
			phase_n = enter_ph;
			wait_n  = '0;
			poll_n  = '0;
		end
		if (load_en) begin
			shift_n = load_val;
			bit_n   = '0;
		end
	end

	// Output logic: line levels follow the phase held before this step.
	always_comb begin
		lines = i2cm_pkg::lines_of(phase_q, shift_q[7]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2cm_pkg::PH_IDLE;
			bit_q       <= '0;
			shift_q     <= '0;
			wait_q      <= '0;
			poll_q      <= '0;
			is_read_q   <= 1'b0;
			held_reg_q  <= '0;
			held_data_q <= '0;
			read_q      <= '0;
			nack_q      <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_n;
			bit_q       <= bit_n;
			shift_q     <= shift_n;
			wait_q      <= wait_n;
			poll_q      <= poll_n;
			is_read_q   <= is_read_n;
			held_reg_q  <= held_reg_n;
			held_data_q <= held_data_n;
			read_q      <= read_n;
			nack_q      <= nack_n;
		end
	end

	// Result register: hold until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			scl_q      <= lines[1];
			pull_q     <= ~lines[0];
			busy_q     <= (phase_n != i2cm_pkg::PH_IDLE);
			done_q     <= (phase_q == i2cm_pkg::PH_SP_END);
			read_out_q <= read_n;
			nack_out_q <= nack_n;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.scl_level    = scl_q;
	assign res.sda_pull_low = pull_q;
	assign res.busy_res     = busy_q;
	assign res.done_res     = done_q;
	assign res.read_result  = read_out_q;
	assign res.nack_seen    = nack_out_q;

	// Idle phase never carries a running wait or poll count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == i2cm_pkg::PH_IDLE) |-> ((wait_q == '0) && (poll_q == '0)))
		else $error("idle phase with nonzero wait or poll count");

	// A stalled input stage keeps its transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step) |=> valid_s1)
		else $error("input stage dropped a stalled transaction");

	// Stop completion always leaves the master not busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.done_res) |-> !res.busy_res)
		else $error("done reported while still busy");

	// Backpressure reaches the command side only when both stages are full.
	assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (valid_s1 && res_valid_q && !res.ready))
		else $error("command channel stalled with a free slot");

	// Sequencer state moves only on a step.
	assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q))
		else $error("phase changed without a step");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the I2C register access master: stimulus, bus prediction, checks.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cm_pkg::*;

	// Operation code that the block treats as a plain tick.
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	localparam int RUN_LIMIT   = 1_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int NO_CAP      = 32'h7fff_ffff;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// Sequencer state as the predictor sees it.
	typedef struct packed {
		phase_t               phase;
		logic [2:0]           bits;
		logic [BYTE_W-1:0]    shreg;
		logic [TICKS_W-1:0]   waited;
		logic [TIMEOUT_W-1:0] polls;
		logic                 rd;
		logic [BYTE_W-1:0]    reg_hold;
		logic [BYTE_W-1:0]    data_hold;
		logic [BYTE_W-1:0]    rd_byte;
		logic                 nack;
	} seq_state_t;

	typedef struct packed {
		logic [ADDR_W-1:0]    dev;
		logic [TICKS_W-1:0]   ticks;
		logic [TIMEOUT_W-1:0] limit;
	} bus_cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] regnum;
		logic [BYTE_W-1:0] wdata;
		logic              sda;
		logic              drain_first; // offer only once every result is back
	} cmd_item_t;

	typedef struct packed {
		logic              scl;
		logic              sda_low;
		logic              busy;
		logic              done;
		logic [BYTE_W-1:0] rdata;
		logic              nack;
	} bus_obs_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_DAT_W-1:0] wr_data;

	i2cm_cmd_if cmd_ch();
	i2cm_res_if res_ch();

	i2c_register_access_master_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.res      (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #1 clk = ~clk;

	bus_cfg_t   bus_cfg;
	seq_state_t pred_st;      // advanced on every accepted command transaction
	seq_state_t plan_st;      // advanced while items are generated, to steer sda_in
	cmd_item_t  pending_cmds[$];
	bus_obs_t   expected_obs[$];
	cmd_item_t  cur;
	int         queued_count  = 0;
	int         checked_count = 0;
	int         fail_count    = 0;
	int         cycle_count   = 0;
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;
	int         hold_asked = 0;
	int         hold_given = 0;
	int         hold_left  = 0;

	function automatic void enter_phase(inout seq_state_t s, input phase_t p);
		s.phase  = p;
		s.waited = '0;
		s.polls  = '0;
	endfunction

	function automatic void load_shift(inout seq_state_t s, input logic [BYTE_W-1:0] b);
		s.shreg = b;
		s.bits  = '0;
	endfunction

	// Advance the bus sequencer by one item and give the observation it yields.
	function automatic void advance_bus(inout seq_state_t s, input bus_cfg_t c,
			input cmd_item_t it, output bus_obs_t o);
		logic [1:0] lv; // {SCL level, SDA released}
		logic over;
		logic fin;
		lv  = 2'b11;
		fin = 1'b0;
		if (s.phase == PH_IDLE) begin
			// A command latches its operands; the lines stay released on this item.
			if ((it.op == OP_WRITE) || (it.op == OP_READ)) begin
				s.reg_hold  = it.regnum;
				s.data_hold = it.wdata;
				s.rd        = (it.op == OP_READ);
				s.nack      = 1'b0;
				enter_phase(s, PH_ST1_A);
			end
		end else begin
			case (s.phase)
				PH_ST1_A, PH_ST2_A, PH_AW_KL, PH_RG_KL, PH_DT_KL, PH_AR_KL,
				PH_RD_LOW, PH_MN_LOW:
					lv = 2'b01;
				PH_ST1_C, PH_ST2_C, PH_SP_HIGH:
					lv = 2'b10;
				PH_ST1_D, PH_ST2_D, PH_SP_LOW:
					lv = 2'b00;
				PH_AW_BL, PH_RG_BL, PH_DT_BL, PH_AR_BL:
					lv = {1'b0, s.shreg[BYTE_W-1]};
				PH_AW_BH, PH_RG_BH, PH_DT_BH, PH_AR_BH:
					lv = {1'b1, s.shreg[BYTE_W-1]};
				default:
					lv = 2'b11;
			endcase
			// The wait count is only looked at in timed phases; every exit resets it.
			s.waited = s.waited + 16'd1;
			over     = (s.waited >= c.ticks);
			case (s.phase)
				PH_ST1_A, PH_ST1_B, PH_ST1_C, PH_ST2_A, PH_ST2_B, PH_ST2_C,
				PH_AW_BL, PH_RG_BL, PH_DT_BL, PH_AR_BL,
				PH_AW_KL, PH_RG_KL, PH_DT_KL, PH_AR_KL,
				PH_RD_LOW, PH_MN_LOW, PH_MN_HIGH, PH_SP_LOW, PH_SP_HIGH:
					if (over) enter_phase(s, phase_t'(s.phase + 5'd1));
				PH_ST1_D:
					if (over) begin
						load_shift(s, {c.dev, 1'b0});
						enter_phase(s, PH_AW_BL);
					end
				PH_ST2_D:
					if (over) begin
						load_shift(s, {c.dev, 1'b1});
						enter_phase(s, PH_AR_BL);
					end
				PH_AW_BH, PH_RG_BH, PH_DT_BH, PH_AR_BH:
					if (over) begin
						s.shreg = {s.shreg[BYTE_W-2:0], 1'b0};
						s.bits  = s.bits + 3'd1;
						enter_phase(s, phase_t'((s.bits == 3'd0) ? (s.phase + 5'd1) :
							(s.phase - 5'd1)));
					end
				PH_AW_KH, PH_RG_KH, PH_DT_KH, PH_AR_KH: begin
					// Poll once per item; the 8-bit count wraps, so a zero limit gives 256.
					s.polls = s.polls + 8'd1;
					if (!it.sda || (s.polls == c.limit)) begin
						if (it.sda) s.nack = 1'b1;
						case (s.phase)
							PH_AW_KH: begin
								load_shift(s, s.reg_hold);
								enter_phase(s, PH_RG_BL);
							end
							PH_RG_KH:
								if (s.rd) begin
									enter_phase(s, PH_ST2_A);
								end else begin
									load_shift(s, s.data_hold);
									enter_phase(s, PH_DT_BL);
								end
							PH_DT_KH:
								enter_phase(s, PH_SP_LOW);
							default: begin
								load_shift(s, '0);
								enter_phase(s, PH_RD_LOW);
							end
						endcase
					end
				end
				PH_RD_HIGH:
					if (over) begin
						s.shreg = {s.shreg[BYTE_W-2:0], it.sda};
						s.bits  = s.bits + 3'd1;
						if (s.bits == 3'd0) begin
							s.rd_byte = s.shreg;
							enter_phase(s, PH_MN_LOW);
						end else begin
							enter_phase(s, PH_RD_LOW);
						end
					end
				default: begin
					// Stop end: SDA released, done raised, back to idle.
					enter_phase(s, PH_IDLE);
					fin = 1'b1;
				end
			endcase
		end
		o.scl     = lv[1];
		o.sda_low = ~lv[0];
		o.busy    = (s.phase != PH_IDLE);
		o.done    = fin;
		o.rdata   = s.rd_byte;
		o.nack    = s.nack;
	endfunction

	task automatic compare_field(input string name, input logic [BYTE_W-1:0] want,
			input logic [BYTE_W-1:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	// Driver: hold valid until the transaction completes, then advance the predictor.
	always @(posedge clk) begin
		bus_obs_t obs;
		if (cmd_ch.valid && cmd_ch.ready) begin
			advance_bus(pred_st, bus_cfg, cur, obs);
			expected_obs.push_back(obs);
		end
		if (!cmd_ch.valid || cmd_ch.ready) begin
			if (arst_n && (pending_cmds.size() != 0) && ($urandom_range(99) >= send_idle_pct)
					&& !(pending_cmds[0].drain_first && (expected_obs.size() != 0))) begin
				cur = pending_cmds.pop_front();
				cmd_ch.valid            <= 1'b1;
				cmd_ch.operation        <= cur.op;
				cmd_ch.register_address <= cur.regnum;
				cmd_ch.write_data       <= cur.wdata;
				cmd_ch.sda_in           <= cur.sda;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver ready: a requested long hold takes precedence over random stalls.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			res_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (hold_asked != hold_given) begin
			res_ch.ready <= 1'b0;
			hold_given   <= hold_asked;
			hold_left    <= HOLD_CYCLES;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		bus_obs_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (expected_obs.size() == 0) begin
				fail_count++;
				$display("%0t ns: result expected none got scl %0b sda_low %0b", $time,
					res_ch.scl_level, res_ch.sda_pull_low);
			end else begin
				want = expected_obs.pop_front();
				compare_field("scl_level", BYTE_W'(want.scl), BYTE_W'(res_ch.scl_level));
				compare_field("sda_pull_low", BYTE_W'(want.sda_low),
					BYTE_W'(res_ch.sda_pull_low));
				compare_field("busy_res", BYTE_W'(want.busy), BYTE_W'(res_ch.busy_res));
				compare_field("done_res", BYTE_W'(want.done), BYTE_W'(res_ch.done_res));
				compare_field("read_result", want.rdata, res_ch.read_result);
				compare_field("nack_seen", BYTE_W'(want.nack), BYTE_W'(res_ch.nack_seen));
			end
			checked_count++;
		end
	end

	// Hand an item to the driver and step the planning copy of the sequencer.
	task automatic offer(input cmd_item_t it);
		bus_obs_t unused;
		advance_bus(plan_st, bus_cfg, it, unused);
		pending_cmds.push_back(it);
		queued_count++;
	endtask

	// Queue one command and the ticks that carry it to its stop, acting as the target:
	// acknowledge unless the refuse mask says otherwise, and present rd_val MSB first.
	task automatic queue_transfer(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] regnum,
			input logic [BYTE_W-1:0] wdata, input logic [BYTE_W-1:0] rd_val,
			input logic [2:0] refuse, input int stray_pct, input int cap, input logic drain);
		cmd_item_t it;
		int n;
		int ack_idx;
		logic refusing;
		it             = '0;
		it.op          = op;
		it.regnum      = regnum;
		it.wdata       = wdata;
		it.sda         = 1'($urandom_range(1));
		it.drain_first = drain;
		offer(it);
		n         = 1;
		ack_idx   = 0;
		refusing  = 1'b0;
		while ((plan_st.phase != PH_IDLE) && (n < cap)) begin
			it.drain_first = 1'b0;
			// Stray commands while busy only count as ticks.
			it.op     = ($urandom_range(99) < stray_pct) ? OP_W'($urandom_range(3)) : OP_TICK;
			it.regnum = BYTE_W'($urandom);
			it.wdata  = BYTE_W'($urandom);
			it.sda    = 1'($urandom_range(1));
			case (plan_st.phase)
				PH_AW_KH, PH_RG_KH, PH_DT_KH, PH_AR_KH: begin
					if (plan_st.polls == '0) begin
						refusing = (ack_idx < 3) ? refuse[ack_idx] : 1'b0;
						ack_idx++;
					end
					// A willing target mostly answers on the first poll.
					it.sda = refusing ? 1'b1 : ($urandom_range(3) == 0);
				end
				PH_RD_HIGH:
					// Only the last item of the high phase is sampled.
					if (int'(plan_st.waited) + 1 >= int'(bus_cfg.ticks))
						it.sda = rd_val[3'd7 - plan_st.bits];
				default: ;
			endcase
			offer(it);
			n++;
		end
	endtask

	// Ticks and spare codes while idle: the block must stay put.
	task automatic queue_idle_noise(input int count);
		cmd_item_t it;
		repeat (count) begin
			it        = '0;
			it.op     = ($urandom_range(1) == 1) ? OP_SPARE : OP_TICK;
			it.regnum = BYTE_W'($urandom);
			it.wdata  = BYTE_W'($urandom);
			it.sda    = 1'($urandom_range(1));
			offer(it);
		end
	endtask

	task automatic wait_drained();
		while (checked_count != queued_count) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			CFG_DEV_ADDR: bus_cfg.dev   = val[ADDR_W-1:0];
			CFG_TICKS:    bus_cfg.ticks = val;
			default:      bus_cfg.limit = val[TIMEOUT_W-1:0];
		endcase
	endtask

	// Write all three registers once the block has gone quiet; unused upper bits are noise.
	task automatic reconfigure(input logic [ADDR_W-1:0] dev, input logic [TICKS_W-1:0] ticks,
			input logic [TIMEOUT_W-1:0] limit);
		wait_drained();
		write_reg(CFG_DEV_ADDR, {9'($urandom), dev});
		write_reg(CFG_TICKS, ticks);
		write_reg(CFG_TIMEOUT, {8'($urandom), limit});
	endtask

	task automatic set_idling(input idle_mode_t m);
		send_idle_pct  = (m == IDLE_SEND) ? 72 : ((m == IDLE_BOTH) ? 33 : 0);
		recv_stall_pct = (m == IDLE_RECV) ? 72 : ((m == IDLE_BOTH) ? 33 : 0);
	endtask

	// Run limit: drop out with a failure if the stimulus never drains.
	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("i2c_register_access_master_core: mismatch");
		$finish;
	end

	initial begin
		int goal;
		logic [TIMEOUT_W-1:0] lim;
		logic [2:0] mask;
		logic rare;
		cmd_ch.valid            = 1'b0;
		cmd_ch.operation        = OP_TICK;
		cmd_ch.register_address = '0;
		cmd_ch.write_data       = '0;
		cmd_ch.sda_in           = 1'b1;
		res_ch.ready            = 1'b0;
		wr_en                   = 1'b0;
		wr_index                = CFG_DEV_ADDR;
		wr_data                 = '0;
		arst_n                  = 1'b0;
		bus_cfg = '{dev: DEV_ADDR_RST, ticks: TICKS_RST, limit: TIMEOUT_RST};
		pred_st = '0;
		plan_st = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: a read whose first acknowledge runs out all 255 polls.
		set_idling(IDLE_BOTH);
		queue_idle_noise(3);
		queue_transfer(OP_READ, 8'h0F, 8'h00, 8'hC3, 3'b001, 0, NO_CAP, 1'b0);

		// Top address, one item per phase: field extremes, refused acknowledges,
		// stray commands mid-transfer. The first command waits for the pipe to empty.
		reconfigure(7'h7F, 16'd1, 8'd2);
		set_idling(IDLE_RECV);
		queue_transfer(OP_WRITE, 8'hFF, 8'hFF, 8'h00, 3'b000, 0, NO_CAP, 1'b1);
		queue_transfer(OP_WRITE, 8'h00, 8'h00, 8'h00, 3'b111, 0, NO_CAP, 1'b0);
		queue_transfer(OP_READ, 8'hA5, 8'h5A, 8'h00, 3'b000, 0, NO_CAP, 1'b0);
		queue_transfer(OP_READ, 8'h5A, 8'hA5, 8'hFF, 3'b100, 0, NO_CAP, 1'b0);
		queue_transfer(OP_WRITE, 8'h3C, 8'hC3, 8'h00, 3'b000, 40, NO_CAP, 1'b0);
		queue_idle_noise(4);

		// Address zero, zero phase length and zero timeout (256 polls on a refusal).
		reconfigure(7'h00, 16'd0, 8'd0);
		set_idling(IDLE_SEND);
		queue_transfer(OP_READ, 8'h81, 8'h18, 8'h7E, 3'b010, 0, NO_CAP, 1'b0);
		queue_transfer(OP_WRITE, 8'h7E, 8'h81, 8'h00, 3'b000, 0, NO_CAP, 1'b0);

		// Random transfers over several settings and idling patterns. In the third
		// pattern each command waits until the idle noise ahead of it has come back.
		for (int p = 0; p < 4; p++) begin
			case ($urandom_range(3))
				0:       lim = 8'd1;
				1:       lim = 8'($urandom_range(12, 2));
				2:       lim = 8'd255;
				default: lim = 8'd0;
			endcase
			reconfigure(ADDR_W'($urandom), 16'($urandom_range(2, 1)), lim);
			set_idling(idle_mode_t'(p % 4));
			// Hold the receiver off for a long stretch while items keep coming.
			if (p == 0) hold_asked++;
			rare = (lim == 8'd0) || (lim > 8'd12);
			goal = queued_count + 60;
			while (queued_count < goal) begin
				queue_idle_noise(1 + int'($urandom_range(2)));
				for (int k = 0; k < 3; k++)
					mask[k] = rare ? ($urandom_range(9) == 0) : ($urandom_range(2) == 0);
				queue_transfer(($urandom_range(1) == 1) ? OP_READ : OP_WRITE,
					BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), mask,
					$urandom_range(8), NO_CAP, (p == 2));
			end
		end

		// Longest phase: run a few dozen items into the first start phase, then stop feeding.
		reconfigure(ADDR_W'($urandom), 16'hFFFF, TIMEOUT_W'($urandom));
		set_idling(IDLE_NONE);
		queue_transfer(OP_WRITE, BYTE_W'($urandom), BYTE_W'($urandom), 8'h00, 3'b000, 0,
			40, 1'b0);

		wait_drained();
		if (fail_count == 0) begin
			$display("i2c_register_access_master_core: match");
		end else begin
			$display("i2c_register_access_master_core: mismatch");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2c_register_access_master_core.sv
verif/tb.sv
